// ===== rtl/rrc_pkg.sv =====
// rrc_pkg: shared types, codes and default sizes for the range rule classifier
// depends on nothing; imported by every module of the block
package rrc_pkg;

  // default sizes, handed to the top level parameters
  localparam int RRC_NUM_RULES   = 16;
  localparam int RRC_PARAM_COUNT = 18;
  localparam int RRC_VALUE_WIDTH = 16;

  // request function codes
  typedef enum logic [1:0] {
    FN_BOUND    = 2'd0,
    FN_HEADER   = 2'd1,
    FN_VALUE    = 2'd2,
    FN_CLASSIFY = 2'd3
  } func_t;

  // rule header word
  typedef struct packed {
    logic [3:0] method;
    logic [7:0] ovr_code;
    logic [4:0] misses;
  } hdr_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_WAIT = 2'd2
  } state_t;

endpackage

// ===== rtl/rrc_ram.sv =====
// rrc_ram: generic single write port, single read port ram with registered read
// depends on rrc_pkg only by house convention
module rrc_ram
  import rrc_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rrc_cell.sv =====
// rrc_cell: one parameter slot of the chain; held value, bound ram and hit adder
// depends on rrc_pkg and rrc_ram
module rrc_cell
  import rrc_pkg::*;
#(
  parameter int NUM_RULES   = RRC_NUM_RULES,
  parameter int PARAM_COUNT = RRC_PARAM_COUNT,
  parameter int VALUE_WIDTH = RRC_VALUE_WIDTH,
  parameter int SLOT        = 0,
  localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1,
  localparam int CNT_W = $clog2(PARAM_COUNT + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_bound_i,
  input  logic                   wr_value_i,
  input  logic [4:0]             wr_slot_i,
  input  logic [IDX_W-1:0]       wr_rule_i,
  input  logic [VALUE_WIDTH-1:0] wr_low_i,
  input  logic [VALUE_WIDTH-1:0] wr_high_i,
  input  logic [VALUE_WIDTH-1:0] wr_value_i_data,
  input  logic                   tok_vld_i,
  input  logic [IDX_W-1:0]       tok_idx_i,
  input  logic [CNT_W-1:0]       tok_hits_i,
  input  logic [IDX_W-1:0]       ahead_idx_i,
  output logic                   tok_vld_o,
  output logic [IDX_W-1:0]       tok_idx_o,
  output logic [CNT_W-1:0]       tok_hits_o,
  output logic [IDX_W-1:0]       ahead_idx_o
);

  logic                          my_slot;
  logic signed [VALUE_WIDTH-1:0] param_r;
  logic [2*VALUE_WIDTH-1:0]      bnd_rdata;
  logic signed [VALUE_WIDTH-1:0] lo;
  logic signed [VALUE_WIDTH-1:0] hi;
  logic                          hit;
  logic                          vld_r;
  logic [IDX_W-1:0]              idx_r;
  logic [CNT_W-1:0]              hits_r;
  logic [CNT_W-1:0]              hits_nxt;

  assign my_slot = (wr_slot_i == 5'(SLOT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_r <= '0;
    end else if (wr_value_i && my_slot) begin
      param_r <= wr_value_i_data;
    end
  end

  // bounds of every rule for this slot, read one token ahead
  rrc_ram #(
    .WIDTH (2 * VALUE_WIDTH),
    .DEPTH (NUM_RULES)
  ) u_bound_ram (
    .clk   (clk),
    .we    (wr_bound_i && my_slot),
    .waddr (wr_rule_i),
    .wdata ({wr_high_i, wr_low_i}),
    .raddr (ahead_idx_i),
    .rdata (bnd_rdata)
  );

  assign lo       = bnd_rdata[VALUE_WIDTH-1:0];
  assign hi       = bnd_rdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign hit      = (param_r >= lo) && (param_r <= hi);
  assign hits_nxt = tok_hits_i + CNT_W'(hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= tok_idx_i;
    hits_r <= hits_nxt;
  end

  assign tok_vld_o   = vld_r;
  assign tok_idx_o   = idx_r;
  assign tok_hits_o  = hits_r;
  assign ahead_idx_o = tok_idx_i;

endmodule

// ===== rtl/range_rule_classifier.sv =====
// range_rule_classifier: top level of the priority range rule classifier
// depends on rrc_pkg, rrc_cell and rrc_ram
//
// A table of NUM_RULES rules is loaded by bound pair and header requests, parameter
// values by value requests; none of these gives a result. A classify
// request walks the rules in priority order through a chain of PARAM_COUNT cells, one per
// parameter slot: a rule token enters the chain each cycle, every cell adds its in-range hit
// to the token's count as it passes, and the collector at the end picks the first rule whose
// override code equals the requested one or whose hits plus allowed misses reach PARAM_COUNT.
// A classify issues one rule per cycle into the chain; no new request is taken until its
// result is loaded into the output register.
// Without a match the configured default method is returned with matched low. The result sits
// in an output register, so requests are taken while it waits. The default method register
// is written on the cfg port, which is always ready. Reading a rule or bound never written
// gives undefined results.
module range_rule_classifier
  import rrc_pkg::*;
#(
  parameter int NUM_RULES   = RRC_NUM_RULES,
  parameter int PARAM_COUNT = RRC_PARAM_COUNT,
  parameter int VALUE_WIDTH = RRC_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [3:0]         in_rule_index,
  input  logic [4:0]         in_slot_index,
  input  logic signed [15:0] in_low_bound,
  input  logic signed [15:0] in_high_bound,
  input  logic [3:0]         in_rule_method,
  input  logic [7:0]         in_rule_override,
  input  logic [4:0]         in_allowed_misses,
  input  logic signed [15:0] in_param_value,
  input  logic [7:0]         in_override_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_method_code,
  output logic               out_by_override,
  output logic               out_matched
);

  localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int CNT_W = $clog2(PARAM_COUNT + 1);
  localparam int SUM_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

  // request decode
  logic             in_acc;
  logic             rule_ok;
  logic             wr_bound;
  logic             wr_hdr;
  logic             wr_value;
  logic             start_scan;
  logic [IDX_W-1:0] wr_rule;

  // configuration
  logic [3:0] cfg_default_r;

  // sequencer
  state_t           state_r;
  state_t           state_nxt;
  logic             issuing_r;
  logic [IDX_W-1:0] issue_cnt_r;
  logic             head_vld_r;
  logic [IDX_W-1:0] head_idx_r;
  logic [7:0]       ovr_r;

  // chain taps, position 0 is the head, position PARAM_COUNT the collector
  logic             tok_vld  [0:PARAM_COUNT];
  logic [IDX_W-1:0] tok_idx  [0:PARAM_COUNT];
  logic [CNT_W-1:0] tok_hits [0:PARAM_COUNT];
  logic [IDX_W-1:0] ahead    [0:PARAM_COUNT];

  // collector
  hdr_t             hdr;
  logic [16:0]      hdr_rdata;
  logic             ovr_hit;
  logic             rng_hit;
  logic             last_tok;
  logic             found_r;
  logic [3:0]       res_method_r;
  logic             res_by_ovr_r;
  logic             load_out;

  // result register
  logic             out_valid_r;
  logic [3:0]       out_method_r;
  logic             out_by_ovr_r;
  logic             out_matched_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_default_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_default_r <= cfg_data;
    end
  end

  // ------------------------------------------------------------------
  // request decode; writes beyond the table are dropped
  // ------------------------------------------------------------------
  assign in_acc     = in_valid && in_ready;
  assign rule_ok    = (32'(in_rule_index) < 32'(NUM_RULES));
  assign wr_rule    = IDX_W'(in_rule_index);
  assign wr_bound   = in_acc && (in_func == FN_BOUND) && rule_ok;
  assign wr_hdr     = in_acc && (in_func == FN_HEADER) && rule_ok;
  assign wr_value   = in_acc && (in_func == FN_VALUE);
  assign start_scan = in_acc && (in_func == FN_CLASSIFY);

  // ------------------------------------------------------------------
  // sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_tok) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  in_ready = 1'b0;
      S_WAIT:  load_out = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issuing_r  <= 1'b0;
      head_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_vld_r <= issuing_r;
      if (start_scan) begin
        issuing_r <= 1'b1;
      end else if (issuing_r && (issue_cnt_r == IDX_W'(NUM_RULES - 1))) begin
        issuing_r <= 1'b0;
      end
    end
  end

  // rule issue counter, one rule token per cycle
  always_ff @(posedge clk) begin
    head_idx_r <= issue_cnt_r;
    if (start_scan) begin
      issue_cnt_r <= '0;
      ovr_r       <= in_override_value;
    end else if (issuing_r) begin
      issue_cnt_r <= issue_cnt_r + 1'b1;
    end
  end

  // ------------------------------------------------------------------
  // chain of slot cells
  // ------------------------------------------------------------------
  assign tok_vld[0]  = head_vld_r;
  assign tok_idx[0]  = head_idx_r;
  assign tok_hits[0] = '0;
  assign ahead[0]    = issue_cnt_r;   // index entering the head next cycle

  for (genvar p = 0; p < PARAM_COUNT; p++) begin : g_cell
    rrc_cell #(
      .NUM_RULES   (NUM_RULES),
      .PARAM_COUNT (PARAM_COUNT),
      .VALUE_WIDTH (VALUE_WIDTH),
      .SLOT        (p)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .wr_bound_i      (wr_bound),
      .wr_value_i      (wr_value),
      .wr_slot_i       (in_slot_index),
      .wr_rule_i       (wr_rule),
      .wr_low_i        (VALUE_WIDTH'(in_low_bound)),
      .wr_high_i       (VALUE_WIDTH'(in_high_bound)),
      .wr_value_i_data (VALUE_WIDTH'(in_param_value)),
      .tok_vld_i       (tok_vld[p]),
      .tok_idx_i       (tok_idx[p]),
      .tok_hits_i      (tok_hits[p]),
      .ahead_idx_i     (ahead[p]),
      .tok_vld_o       (tok_vld[p+1]),
      .tok_idx_o       (tok_idx[p+1]),
      .tok_hits_o      (tok_hits[p+1]),
      .ahead_idx_o     (ahead[p+1])
    );
  end

  // ------------------------------------------------------------------
  // collector: header read one token ahead, first qualifying rule wins
  // ------------------------------------------------------------------
  rrc_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (NUM_RULES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (wr_hdr),
    .waddr (wr_rule),
    .wdata ({in_rule_method, in_rule_override, in_allowed_misses}),
    .raddr (ahead[PARAM_COUNT]),
    .rdata (hdr_rdata)
  );

  assign hdr      = hdr_t'(hdr_rdata);
  assign ovr_hit  = (hdr.ovr_code == ovr_r);
  // hits >= count - misses, kept unsigned
  assign rng_hit  = (SUM_W'(tok_hits[PARAM_COUNT]) + SUM_W'(hdr.misses)) >= SUM_W'(PARAM_COUNT);
  assign last_tok = tok_vld[PARAM_COUNT] && (tok_idx[PARAM_COUNT] == IDX_W'(NUM_RULES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start_scan) begin
      found_r <= 1'b0;
    end else if (tok_vld[PARAM_COUNT] && (ovr_hit || rng_hit)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_vld[PARAM_COUNT] && !found_r && (ovr_hit || rng_hit)) begin
      res_method_r <= hdr.method;
      res_by_ovr_r <= ovr_hit;
    end
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_method_r  <= found_r ? res_method_r : cfg_default_r;
      out_by_ovr_r  <= found_r && res_by_ovr_r;
      out_matched_r <= found_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_method_code = out_method_r;
  assign out_by_override = out_by_ovr_r;
  assign out_matched     = out_matched_r;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // a result appears only after a completed scan
  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WAIT))
    else $error("result raised outside the wait state");

  // rule tokens reach the collector only while scanning
  a_tok_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld[PARAM_COUNT] |-> (state_r == S_SCAN))
    else $error("rule token at collector outside a scan");

  // rule issue only runs during a scan
  a_issue_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> (state_r == S_SCAN))
    else $error("rule issue active outside a scan");

  // an override result is always a match
  a_ovr_is_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_by_ovr_r) |-> out_matched_r)
    else $error("override flag without match");

endmodule
